// ===== hdl/bm3_pkg.sv =====
`default_nettype none

package bm3_pkg;

  // Largest frame the line stores and counters are built for.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Fixed widths of the register fields.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Column runs 0..MAX_WIDTH-1, row runs 0..MAX_HEIGHT+1.
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_OP_MODE      = 2'd2
  } cfg_index_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_kind_t;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } op_mode_t;

  typedef struct packed {
    logic result_on;
    logic last_of_frame;
  } out_item_t;

  // Clamp a frame dimension to 1..maxv.
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      res = CFG_W'(maxv);
    end
    return res;
  endfunction

  // 3x3 window, bit index row*3 + col, row 0 on top, col 0 on the left.
  // Neighbors on a side whose flag is low lie outside the frame.
  function automatic logic morph_filter(input logic [8:0] win,
                                        input logic top_ok,
                                        input logic bot_ok,
                                        input logic left_ok,
                                        input logic right_ok,
                                        input op_mode_t mode);
    logic [8:0] use_mask;
    logic       any_set;
    logic       any_clear;
    logic       res;
    use_mask = 9'b111_101_111;
    if (!top_ok) begin
      use_mask = use_mask & 9'b111_111_000;
    end
    if (!bot_ok) begin
      use_mask = use_mask & 9'b000_111_111;
    end
    if (!left_ok) begin
      use_mask = use_mask & 9'b110_110_110;
    end
    if (!right_ok) begin
      use_mask = use_mask & 9'b011_011_011;
    end
    any_set   = |(win & use_mask);
    any_clear = |(~win & use_mask);
    if (mode == MODE_DILATE) begin
      res = win[4] | any_set;
    end else begin
      res = win[4] & ~any_clear;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bm3_ifs.sv =====
`default_nettype none

// Pixel request channel.
interface bm3_pix_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pixel_on;

  modport source (output valid, output req_type, output pixel_on, input ready);
  modport sink (input valid, input req_type, input pixel_on, output ready);
endinterface

// Filtered pixel channel.
interface bm3_res_if;
  logic valid;
  logic ready;
  logic result_on;
  logic last_of_frame;

  modport source (output valid, output result_on, output last_of_frame, input ready);
  modport sink (input valid, input result_on, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hdl/bm3_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one read port, registered read.
// A read at the address being written returns the old contents.
module bm3_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/binary_morphology_3x3_unit.sv =====
`default_nettype none

// Binary 3x3 erosion or dilation on a raster-order pixel stream. Pixels of a
// frame enter row by row on in_pix, one transfer per clock unless ready is low;
// each transfer is handled in the cycle it is taken and its result, if any, sits in
// a two-entry output buffer from the next cycle on, so the input keeps taking
// transfers while one result waits on out_pix. The result for pixel (r, c)
// comes out with the transfer of the pixel one row and one column later, so a
// frame of W x H pixels needs W*H + W + 1 input transfers: the pixels and then
// W + 1 flush transfers (req_type = 1). A flush while no frame is in progress
// gives nothing. The two previous rows live in one 2-bit wide line RAM of
// MAX_WIDTH entries, read one column ahead so that the registered read lines up
// with the next transfer; its contents need no clearing after reset, since rows
// that were never written are always treated as outside the frame. Any
// register write abandons the frame in progress; write registers only while
// the block is idle. Width and height of zero count as one.
module binary_morphology_3x3_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bm3_pix_if.sink                               in_pix,
  bm3_res_if.source                             out_pix,
  input  wire logic                             cfg_we,
  input  wire logic [bm3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bm3_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration, stored already clamped.
  logic [bm3_pkg::CFG_W-1:0] fw_r;
  logic [bm3_pkg::CFG_W-1:0] fh_r;
  bm3_pkg::op_mode_t         mode_r;
  logic                      cfg_hit;

  // Raster position and the sliding window.
  logic [bm3_pkg::COL_W-1:0] col_r;
  logic [bm3_pkg::COL_W-1:0] col_nxt;
  logic [bm3_pkg::ROW_W-1:0] row_r;
  logic [bm3_pkg::ROW_W-1:0] row_nxt;
  logic [8:0]                win_r;
  logic [8:0]                win_nxt;

  // Line RAM: bit 1 is the upper row, bit 0 the middle row.
  logic [1:0]                ram_q;
  logic [1:0]                byp_data_r;
  logic                      byp_r;
  logic [1:0]                line_bits;
  logic                      up_bit;
  logic                      mid_bit;

  // Per-transfer datapath.
  logic                      accept;
  logic                      is_flush;
  logic                      idle_flush;
  logic                      step;
  logic                      pix;
  logic [8:0]                shifted;
  logic [8:0]                win_new;
  logic [31:0]               r32;
  logic [31:0]               c32;
  logic [31:0]               w32;
  logic [31:0]               h32;
  logic                      col0_emit;
  logic                      inner_emit;
  logic                      col0_res;
  logic                      inner_res;
  logic                      emitted;
  logic                      last;
  bm3_pkg::out_item_t        new_item;

  // Output buffer.
  bm3_pkg::out_item_t        q_r [2];
  bm3_pkg::out_item_t        q_nxt [2];
  logic [1:0]                cnt_r;
  logic [1:0]                cnt_nxt;
  logic                      pop;
  logic [1:0]                wr_slot;

  // Configuration writes. An index past the register list is ignored.
  assign cfg_hit = cfg_we && (cfg_index == bm3_pkg::CFG_FRAME_WIDTH ||
                              cfg_index == bm3_pkg::CFG_FRAME_HEIGHT ||
                              cfg_index == bm3_pkg::CFG_OP_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= bm3_pkg::FRAME_WIDTH_RST;
      fh_r   <= bm3_pkg::FRAME_HEIGHT_RST;
      mode_r <= bm3_pkg::MODE_ERODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bm3_pkg::CFG_FRAME_WIDTH: begin
          fw_r <= bm3_pkg::clamp_dim(cfg_wdata, bm3_pkg::MAX_WIDTH);
        end
        bm3_pkg::CFG_FRAME_HEIGHT: begin
          fh_r <= bm3_pkg::clamp_dim(cfg_wdata, bm3_pkg::MAX_HEIGHT);
        end
        bm3_pkg::CFG_OP_MODE: begin
          mode_r <= bm3_pkg::op_mode_t'(cfg_wdata[0]);
        end
        default: begin
        end
      endcase
    end
  end

  // The buffer takes a transfer whenever it has a free entry.
  assign in_pix.ready = (cnt_r != 2'd2);
  assign accept       = in_pix.valid && in_pix.ready;
  assign is_flush     = (bm3_pkg::req_kind_t'(in_pix.req_type) == bm3_pkg::REQ_FLUSH);
  assign idle_flush   = is_flush && (row_r == '0) && (col_r == '0);
  assign step         = accept && !idle_flush;
  assign pix          = is_flush ? 1'b0 : in_pix.pixel_on;

  // A write and a read of the same column in one cycle (a one-pixel-wide
  // frame) is forwarded around the RAM.
  assign line_bits = byp_r ? byp_data_r : ram_q;
  assign up_bit    = line_bits[1];
  assign mid_bit   = line_bits[0];

  assign r32 = 32'(row_r);
  assign c32 = 32'(col_r);
  assign w32 = 32'(fw_r);
  assign h32 = 32'(fh_r);

  // Shift the window one column to the left and bring in the new column.
  assign shifted = {1'b0, win_r[8:1]} & 9'b011_011_011;
  assign win_new = shifted | {pix, 2'b00, mid_bit, 2'b00, up_bit, 2'b00};

  // At column zero the window still holds the end of row r-2, which is
  // finished here with its right neighbors outside the frame.
  assign col0_emit = (col_r == '0) && (r32 >= 32'd2) && (r32 < h32 + 32'd2);
  assign col0_res  = bm3_pkg::morph_filter(shifted, r32 >= 32'd3, r32 <= h32,
                                           w32 >= 32'd2, 1'b0, mode_r);

  // Elsewhere the new window is centered on pixel (r-1, c-1).
  assign inner_emit = (col_r != '0) && (r32 >= 32'd1) && (r32 <= h32);
  assign inner_res  = bm3_pkg::morph_filter(win_new, r32 >= 32'd2, r32 < h32,
                                            c32 >= 32'd2, 1'b1, mode_r);

  assign emitted = step && (col0_emit || inner_emit);
  // The bottom-right pixel of the frame is always finished at column zero
  // of the row after the last flush row.
  assign last    = col0_emit && (r32 == h32 + 32'd1);

  assign new_item.result_on     = col0_emit ? col0_res : inner_res;
  assign new_item.last_of_frame = last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
      win_nxt = '0;
    end else if (step) begin
      win_nxt = win_new;
      if (emitted && last) begin
        col_nxt = '0;
        row_nxt = '0;
        win_nxt = '0;
      end else if (c32 + 32'd1 >= w32) begin
        col_nxt = '0;
        row_nxt = row_r + {{(bm3_pkg::ROW_W-1){1'b0}}, 1'b1};
        if (r32 + 32'd1 > h32 + 32'd1) begin
          row_nxt = '0;
          win_nxt = '0;
        end
      end else begin
        col_nxt = col_r + {{(bm3_pkg::COL_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
      byp_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= win_nxt;
      byp_r <= step && (col_r == col_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= {mid_bit, pix};
  end

  // The read address is the column of the next transfer, so its row bits are
  // waiting in the RAM output register when that transfer arrives.
  bm3_ram #(
    .WIDTH (2),
    .DEPTH (bm3_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (step),
    .waddr (col_r),
    .wdata ({mid_bit, pix}),
    .raddr (col_nxt),
    .rdata (ram_q)
  );

  // Two-entry output buffer, head in entry zero.
  assign pop     = (cnt_r != 2'd0) && out_pix.ready;
  assign wr_slot = cnt_r - {1'b0, pop};

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (emitted) begin
      if (wr_slot == 2'd0) begin
        q_nxt[0] = new_item;
      end else begin
        q_nxt[1] = new_item;
      end
    end
    cnt_nxt = cnt_r + {1'b0, emitted} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_pix.valid         = (cnt_r != 2'd0);
  assign out_pix.result_on     = q_r[0].result_on;
  assign out_pix.last_of_frame = q_r[0].last_of_frame;

endmodule

`default_nettype wire

// ===== hdl/bm3_checker.sv =====
`default_nettype none

// Port-level checks for the morphology unit.
module bm3_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic result_on,
  input wire logic last_of_frame
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_on) &&
                                $stable(last_of_frame))
    else $error("output changed while stalled");

  // With no result waiting the input side is always open.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output buffer");

  // A full buffer that gives nothing away stays full.
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !(out_valid && out_ready) |=> !in_ready)
    else $error("input reopened without an output transfer");

  // Draining a result without taking a new pixel frees an entry.
  a_drain_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !(in_valid && in_ready) |=> in_ready)
    else $error("input still blocked after an output transfer");

endmodule

bind binary_morphology_3x3_unit bm3_checker u_bm3_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_pix.valid),
  .out_ready     (out_pix.ready),
  .result_on     (out_pix.result_on),
  .last_of_frame (out_pix.last_of_frame)
);

`default_nettype wire
